>>> rtl/assert_macros.svh
// Assertion helpers for the RTL modules; only the face normal top uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TFN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define TFN_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal package
// Widths and shared types of the face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 16;
    localparam int A_W     = 30;
    localparam int SUM_W   = 62;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 31;
    localparam int FRAC_W  = 14;
    localparam int Q_W     = 15;
    localparam int NUM_W   = A_W + FRAC_W + 1;
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam logic [Q_W-1:0] Q_MAX = Q_W'(16384);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [NORM_W-1:0]  t_norm;
    typedef logic [LEN_W-1:0]          t_len;
    typedef logic [SUM_W-1:0]          t_sum;

    typedef struct packed {
        logic [2:0][A_W-1:0] a;
        logic [2:0]          neg;
        logic                degen;
    } t_side;

    typedef struct packed {
        logic [2:0][Q_W-1:0] q;
        logic [2:0]          neg;
        logic                degen;
    } t_quot;

endpackage

>>> rtl/tfn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal channels
// Input channel for one triangle and output channel for one normal.
// ----------------------------------------------------------------------------
interface tfn_in_if;
    logic            valid;
    logic            ready;
    tfn_pkg::t_coord first_x;
    tfn_pkg::t_coord first_y;
    tfn_pkg::t_coord first_z;
    tfn_pkg::t_coord second_x;
    tfn_pkg::t_coord second_y;
    tfn_pkg::t_coord second_z;
    tfn_pkg::t_coord third_x;
    tfn_pkg::t_coord third_y;
    tfn_pkg::t_coord third_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
                  second_z, third_x, third_y, third_z, output ready);
endinterface

interface tfn_out_if;
    logic           valid;
    logic           ready;
    tfn_pkg::t_norm normal_x;
    tfn_pkg::t_norm normal_y;
    tfn_pkg::t_norm normal_z;
    logic           degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                    input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                  output ready);
endinterface

>>> rtl/tfn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal front end
// Edges, exact cross product, magnitude scaling and sum of squares.
// ----------------------------------------------------------------------------
module tfn_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  tfn_pkg::t_coord [8:0]   i_vtx,
    output logic                    o_valid,
    output tfn_pkg::t_sum           o_sum,
    output tfn_pkg::t_side          o_side
);
    import tfn_pkg::*;

    logic [7:0] r_vld;

    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [65:0] r_p  [6];
    logic signed [66:0] r_c  [3];
    logic [66:0]        r_mag4 [3];
    logic [2:0]         r_neg4;
    logic [66:0]        r_mag5 [3];
    logic [2:0]         r_neg5;
    logic [6:0]         r_blen;
    t_side              r_side6;
    logic [59:0]        r_sq [3];
    t_side              r_side7;
    t_sum               r_sum;
    t_side              r_side8;

    logic [66:0] n_or;
    logic [6:0]  n_blen;
    t_side       n_side6;
    logic [66:0] n_sh;

    always_comb begin
        n_or = r_mag4[0] | r_mag4[1] | r_mag4[2];
        n_blen = '0;
        for (int i = 0; i < 67; i++) begin
            if (n_or[i]) begin
                n_blen = 7'(i + 1);
            end
        end
    end

    always_comb begin
        n_side6 = '0;
        n_sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_blen > 7'(A_W)) begin
                n_sh = r_mag5[i] >> (r_blen - 7'(A_W));
            end else begin
                n_sh = r_mag5[i] << (7'(A_W) - r_blen);
            end
            n_side6.a[i] = n_sh[A_W-1:0];
        end
        n_side6.neg = r_neg5;
        n_side6.degen = (r_blen == 7'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= $signed({i_vtx[3+i][31], i_vtx[3+i]})
                         - $signed({i_vtx[i][31], i_vtx[i]});
                r_e2[i] <= $signed({i_vtx[6+i][31], i_vtx[6+i]})
                         - $signed({i_vtx[i][31], i_vtx[i]});
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= 67'(r_p[2*i]) - 67'(r_p[2*i+1]);
                r_neg4[i] <= r_c[i][66];
                r_mag4[i] <= r_c[i][66] ? 67'(-r_c[i]) : 67'(r_c[i]);
                r_mag5[i] <= r_mag4[i];
                r_sq[i] <= 60'(r_side6.a[i]) * 60'(r_side6.a[i]);
            end
            r_neg5  <= r_neg4;
            r_blen  <= n_blen;
            r_side6 <= n_side6;
            r_side7 <= r_side6;
            r_sum   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_side8 <= r_side7;
        end
    end

    assign o_valid = r_vld[7];
    assign o_sum   = r_sum;
    assign o_side  = r_side8;

endmodule

>>> rtl/tfn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tfn_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tfn_pkg::t_sum  i_sum,
    input  tfn_pkg::t_side i_side,
    output logic           o_valid,
    output tfn_pkg::t_len  o_len,
    output tfn_pkg::t_side o_side
);
    import tfn_pkg::*;

    logic [SQ_W-1:0] r_x    [SQRT_STAGES+1];
    logic [SQ_W-1:0] r_res  [SQRT_STAGES+1];
    t_side           r_side [SQRT_STAGES+1];
    logic [SQRT_STAGES:0] r_vld;

    always_comb begin
        r_x[0]    = SQ_W'(i_sum);
        r_res[0]  = '0;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * (SQRT_STAGES - 1 - s));
        logic [SQ_W-1:0] n_t;
        logic [SQ_W-1:0] n_x;
        logic [SQ_W-1:0] n_res;

        always_comb begin
            n_t = r_res[s] + Bit;
            if (r_x[s] >= n_t) begin
                n_x   = r_x[s] - n_t;
                n_res = (r_res[s] >> 1) + Bit;
            end else begin
                n_x   = r_x[s];
                n_res = r_res[s] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1]    <= n_x;
                r_res[s+1]  <= n_res;
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_vld[SQRT_STAGES];
    assign o_len   = r_res[SQRT_STAGES][LEN_W-1:0];
    assign o_side  = r_side[SQRT_STAGES];

endmodule

>>> rtl/tfn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal divider
// Rounded division of each scaled component by the length, one quotient
// bit per stage in three lanes.
// ----------------------------------------------------------------------------
module tfn_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tfn_pkg::t_len  i_len,
    input  tfn_pkg::t_side i_side,
    output logic           o_valid,
    output tfn_pkg::t_quot o_quot
);
    import tfn_pkg::*;

    logic [2:0][NUM_W-1:0] r_rem [Q_W+1];
    logic [2:0][Q_W-1:0]   r_q   [Q_W+1];
    t_len                  r_len [Q_W+1];
    logic [2:0]            r_neg [Q_W+1];
    logic                  r_dg  [Q_W+1];
    logic [Q_W:0]          r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= {1'b0, i_side.a[i], FRAC_W'(0)}
                             + NUM_W'(i_len >> 1);
            end
            r_q[0]   <= '0;
            r_len[0] <= i_len;
            r_neg[0] <= i_side.neg;
            r_dg[0]  <= i_side.degen;
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int Sh = Q_W - 1 - s;
        logic [NUM_W-1:0]      n_d;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][Q_W-1:0]   n_q;

        always_comb begin
            n_d = NUM_W'(r_len[s]) << Sh;
            n_rem = r_rem[s];
            n_q = r_q[s];
            for (int i = 0; i < 3; i++) begin
                if (r_rem[s][i] >= n_d) begin
                    n_rem[i]   = r_rem[s][i] - n_d;
                    n_q[i][Sh] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_q[s+1]   <= n_q;
                r_len[s+1] <= r_len[s];
                r_neg[s+1] <= r_neg[s];
                r_dg[s+1]  <= r_dg[s];
            end
        end
    end

    assign o_valid      = r_vld[Q_W];
    assign o_quot.q     = r_q[Q_W];
    assign o_quot.neg   = r_neg[Q_W];
    assign o_quot.degen = r_dg[Q_W];

endmodule

>>> rtl/triangle_face_normal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal
// Unit normal of a triangle from its three vertices, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle while the output is not stalled; the 32
// square root stages and the 15 divider stages each retire one result bit per cycle.
// A stall on the output holds the whole pipeline in place.
// Reset clears all valid bits; the block accepts input in the first cycle
// after reset.
`include "assert_macros.svh"

module triangle_face_normal_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfn_in_if.sink    i_in,
    tfn_out_if.source o_out
);
    import tfn_pkg::*;

    logic         w_en;
    t_coord [8:0] w_vtx;
    logic         w_f_valid;
    t_sum         w_f_sum;
    t_side        w_f_side;
    logic         w_s_valid;
    t_len         w_s_len;
    t_side        w_s_side;
    logic         w_d_valid;
    t_quot        w_d_quot;

    logic         r_out_valid;
    t_norm [2:0]  r_norm;
    logic         r_degen;
    t_norm [2:0]  n_norm;
    logic [Q_W-1:0] n_q;

    assign w_en = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_vtx = {i_in.third_z, i_in.third_y, i_in.third_x,
                    i_in.second_z, i_in.second_y, i_in.second_x,
                    i_in.first_z, i_in.first_y, i_in.first_x};

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_vtx   (w_vtx),
        .o_valid (w_f_valid),
        .o_sum   (w_f_sum),
        .o_side  (w_f_side)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_sum   (w_f_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .o_len   (w_s_len),
        .o_side  (w_s_side)
    );

    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_len   (w_s_len),
        .i_side  (w_s_side),
        .o_valid (w_d_valid),
        .o_quot  (w_d_quot)
    );

    always_comb begin
        n_norm = '0;
        n_q = '0;
        for (int i = 0; i < 3; i++) begin
            n_q = (w_d_quot.q[i] > Q_MAX) ? Q_MAX : w_d_quot.q[i];
            if (w_d_quot.degen) begin
                n_norm[i] = '0;
            end else if (w_d_quot.neg[i]) begin
                n_norm[i] = -$signed(NORM_W'(n_q));
            end else begin
                n_norm[i] = $signed(NORM_W'(n_q));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_norm  <= n_norm;
            r_degen <= w_d_quot.degen;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.normal_x   = r_norm[0];
    assign o_out.normal_y   = r_norm[1];
    assign o_out.normal_z   = r_norm[2];
    assign o_out.degenerate = r_degen;

    `TFN_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, r_out_valid && r_degen, r_norm == '0, "degenerate normal not zero")
    `TFN_ASSERT_IMPL(a_nondegen_nonzero, i_clk, i_rst_n, r_out_valid && !r_degen, r_norm != '0, "normal of a proper triangle is zero")
    `TFN_ASSERT(a_range, i_clk, i_rst_n, !r_out_valid || (r_norm[0] <= 16'sd16384 && r_norm[0] >= -16'sd16384 && r_norm[1] <= 16'sd16384 && r_norm[1] >= -16'sd16384 && r_norm[2] <= 16'sd16384 && r_norm[2] >= -16'sd16384), "normal component out of range")

endmodule

>>> tb/tb_triangle_face_normal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal testbench
// Drives triangles into the face normal pipeline with random idle bursts on
// both channels, predicts each unit normal with an exact wide-integer model,
// and compares every output transaction with the oldest expected normal.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_top;
    import tfn_pkg::*;

    typedef struct {
        t_coord v[9];
    } t_tri;

    typedef struct {
        t_norm nx;
        t_norm ny;
        t_norm nz;
        logic  degen;
    } t_normal;

    localparam int LATENCY = 56;
    localparam int MAX_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tfn_in_if  in_ch();
    tfn_out_if out_ch();

    triangle_face_normal_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_tri    pending_tris[$];
    t_normal expected_normals[$];
    int      mismatches = 0;
    int      normals_checked = 0;
    int      degenerate_seen = 0;
    int      cycle_count = 0;
    bit      quiet_phase = 1'b0;
    bit      hold_sink = 1'b0;
    bit      hold_source = 1'b0;
    bit      in_accepted = 1'b0;
    int      src_gap = 0;
    int      sink_gap = 0;

    function automatic int unsigned bit_length(logic [67:0] m);
        int unsigned n;
        n = 0;
        for (int i = 0; i < 68; i++) begin
            if (m[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_normal face_normal(t_tri t);
        logic signed [32:0]  e1[3];
        logic signed [32:0]  e2[3];
        logic signed [67:0]  c[3];
        logic [67:0]         mag[3];
        logic [63:0]         a[3];
        logic [63:0]         len;
        logic [63:0]         q;
        int unsigned         blen;
        t_normal             res;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 33'(t.v[3 + i]) - 33'(t.v[i]);
            e2[i] = 33'(t.v[6 + i]) - 33'(t.v[i]);
        end
        c[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
        c[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
        c[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
        blen = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? 68'(-c[i]) : 68'(c[i]);
            if (bit_length(mag[i]) > blen) begin
                blen = bit_length(mag[i]);
            end
        end
        res = '{0, 0, 0, 1'b1};
        if (blen == 0) begin
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            if (blen > 30) begin
                a[i] = 64'(mag[i] >> (blen - 30));
            end else begin
                a[i] = 64'(mag[i] << (30 - blen));
            end
        end
        len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 14) + (len >> 1)) / len;
            if (q > 64'd16384) begin
                q = 64'd16384;
            end
            if (c[i] < 0) begin
                q = -q;
            end
            case (i)
                0: res.nx = t_norm'(q);
                1: res.ny = t_norm'(q);
                default: res.nz = t_norm'(q);
            endcase
        end
        res.degen = 1'b0;
        return res;
    endfunction

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return t_coord'($urandom_range(0, 8)) - 4;
            3, 4: return t_coord'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic add_tri(t_coord p[9]);
        t_tri t;
        foreach (p[i]) t.v[i] = p[i];
        pending_tris.insert(pending_tris.size(), t);
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sender: presents the head of the queue, with random idle bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_accepted) begin
                void'(pending_tris.pop_front());
            end
            if (in_ch.valid && !in_accepted) begin
                in_ch.valid <= 1'b1;
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (!quiet_phase && !hold_source && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 3);
                in_ch.valid <= 1'b0;
            end else if (hold_source || pending_tris.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else begin
                automatic t_tri t;
                t = pending_tris[0];
                in_ch.valid <= 1'b1;
                in_ch.first_x <= t.v[0];
                in_ch.first_y <= t.v[1];
                in_ch.first_z <= t.v[2];
                in_ch.second_x <= t.v[3];
                in_ch.second_y <= t.v[4];
                in_ch.second_z <= t.v[5];
                in_ch.third_x <= t.v[6];
                in_ch.third_y <= t.v[7];
                in_ch.third_z <= t.v[8];
            end
        end
    end

    // Receiver readiness: random stall bursts, or a forced long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            out_ch.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitors: record each accepted triangle and check each normal.
    always @(posedge i_clk) begin
        in_accepted <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            automatic t_tri t;
            t.v = '{in_ch.first_x, in_ch.first_y, in_ch.first_z,
                    in_ch.second_x, in_ch.second_y, in_ch.second_z,
                    in_ch.third_x, in_ch.third_y, in_ch.third_z};
            expected_normals.insert(expected_normals.size(), face_normal(t));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected normal transaction: %0d %0d %0d deg=%0b",
                             out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
                             out_ch.degenerate);
                end
            end else begin
                automatic t_normal e = expected_normals.pop_front();
                normals_checked++;
                if (out_ch.degenerate) begin
                    degenerate_seen++;
                end
                if (out_ch.normal_x !== e.nx || out_ch.normal_y !== e.ny ||
                    out_ch.normal_z !== e.nz || out_ch.degenerate !== e.degen) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"Normal mismatch: expected %0d %0d %0d deg=%0b, ",
                                  "got %0d %0d %0d deg=%0b"},
                                 e.nx, e.ny, e.nz, e.degen, out_ch.normal_x,
                                 out_ch.normal_y, out_ch.normal_z, out_ch.degenerate);
                    end
                end
            end
        end
    end

    initial begin
        t_coord p[9];
        t_coord ext[4];
        in_ch.valid = 1'b0;
        in_ch.first_x = '0;
        in_ch.first_y = '0;
        in_ch.first_z = '0;
        in_ch.second_x = '0;
        in_ch.second_y = '0;
        in_ch.second_z = '0;
        in_ch.third_x = '0;
        in_ch.third_y = '0;
        in_ch.third_z = '0;
        out_ch.ready = 1'b0;
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

        // Directed triangles: axis-aligned faces, degenerate shapes, extremes.
        add_tri('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0});
        add_tri('{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0});
        add_tri('{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
        add_tri('{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0});
        add_tri('{5, 6, 7, 5, 6, 7, 9, 1, 2});
        add_tri('{5, 6, 7, 9, 1, 2, 5, 6, 7});
        add_tri('{0, 0, 0, 1, 2, 3, 2, 4, 6});
        add_tri('{1, 1, 1, 1, 1, 1, 1, 1, 1});
        add_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        add_tri('{0, 0, 0, 1, 1, 1, 1, 1, 0});
        for (int k = 0; k < 12; k++) begin
            foreach (p[i]) p[i] = ext[(k + i * (k + 1)) % 4];
            add_tri(p);
        end
        add_tri('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000});
        add_tri('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < 1580; n++) begin
            if (n == 500) begin
                // Long receiver hold-off while triangles keep coming.
                wait (pending_tris.size() == 0);
                hold_sink = 1'b1;
                for (int k = 0; k < 150; k++) begin
                    foreach (p[i]) p[i] = pick_coord();
                    add_tri(p);
                end
                repeat (200) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            if (n == 900) begin
                // Sender pauses until the pipeline has drained.
                wait (pending_tris.size() == 0);
                hold_source = 1'b1;
                wait (expected_normals.size() == 0);
                hold_source = 1'b0;
            end
            if (n == 1400) begin
                quiet_phase = 1'b1;
            end
            case ($urandom_range(0, 4))
                0: begin
                    // Collinear or repeated vertices.
                    foreach (p[i]) p[i] = pick_coord();
                    if ($urandom_range(0, 1)) begin
                        for (int i = 0; i < 3; i++) p[3 + i] = p[i];
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            p[3 + i] = p[i] + 3 * (t_coord'($urandom_range(0, 20)) - 10);
                            p[6 + i] = p[i] + 2 * (p[3 + i] - p[i]);
                        end
                    end
                end
                default: foreach (p[i]) p[i] = pick_coord();
            endcase
            add_tri(p);
        end

        wait (pending_tris.size() == 0 && expected_normals.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d normals, %0d degenerate, including extreme and collinear triangles.",
                 normals_checked, degenerate_seen);
        if (mismatches == 0 && expected_normals.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d normals missing", mismatches,
                     expected_normals.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
